[rtl/core/pscls_pkg.sv]
// ----------------------------------------------------------------------------
// pscls_pkg
// Types, codes and keyword lookup shared by the plain scalar classifier.
// ----------------------------------------------------------------------------
package pscls_pkg;

   localparam int CHAR_W   = 8;
   localparam int PREFIX_W = 40;
   localparam int COUNT_W  = 3;
   localparam int VALUE_W  = 64;
   localparam int CLASS_W  = 3;

   typedef enum logic [CLASS_W-1:0] {
      CLS_STRING  = 3'd0,
      CLS_NULL    = 3'd1,
      CLS_TRUE    = 3'd2,
      CLS_FALSE   = 3'd3,
      CLS_INTEGER = 3'd4
   } class_type;

   typedef enum logic [1:0] {
      SGN_NONE  = 2'd0,
      SGN_PLUS  = 2'd1,
      SGN_MINUS = 2'd2
   } sign_type;

   typedef enum logic [1:0] {
      PH_PRE  = 2'd0,
      PH_SPEC = 2'd1,
      PH_POST = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_BIN = 2'd1,
      RX_OCT = 2'd2,
      RX_HEX = 2'd3
   } radix_type;

   typedef struct packed {
      logic [PREFIX_W-1:0] prefix;
      logic [COUNT_W-1:0]  count;
      sign_type            sign;
      logic                not_int;
      phase_type           phase;
      radix_type           radix;
      logic [VALUE_W-1:0]  acc;
   } scan_type;

   typedef struct packed {
      scan_type scan;
      logic     quoted;
   } snap_type;

   localparam scan_type SCAN_CLEAR = '{
      prefix:  '0,
      count:   '0,
      sign:    SGN_NONE,
      not_int: 1'b0,
      phase:   PH_PRE,
      radix:   RX_DEC,
      acc:     '0
   };

   // byte order swap: first character of a literal goes to the low byte
   function automatic logic [15:0] le2(input logic [15:0] s);
      return {s[7:0], s[15:8]};
   endfunction

   function automatic logic [23:0] le3(input logic [23:0] s);
      return {s[7:0], s[15:8], s[23:16]};
   endfunction

   function automatic logic [31:0] le4(input logic [31:0] s);
      return {s[7:0], s[15:8], s[23:16], s[31:24]};
   endfunction

   function automatic logic [39:0] le5(input logic [39:0] s);
      return {s[7:0], s[15:8], s[23:16], s[31:24], s[39:32]};
   endfunction

   function automatic class_type kw_class(input logic [PREFIX_W-1:0] p,
                                          input logic [COUNT_W-1:0] n);
      class_type k;
      k = CLS_STRING;
      unique case (n)
         3'd0: k = CLS_NULL;
         3'd1: begin
            if (p[7:0] == "~") k = CLS_NULL;
            else if (p[7:0] == "y" || p[7:0] == "Y") k = CLS_TRUE;
            else if (p[7:0] == "n" || p[7:0] == "N") k = CLS_FALSE;
         end
         3'd2: begin
            if (p[15:0] == le2("on") || p[15:0] == le2("On") || p[15:0] == le2("ON"))
               k = CLS_TRUE;
            else if (p[15:0] == le2("no") || p[15:0] == le2("No")
                     || p[15:0] == le2("NO"))
               k = CLS_FALSE;
         end
         3'd3: begin
            if (p[23:0] == le3("yes") || p[23:0] == le3("Yes")
                || p[23:0] == le3("YES"))
               k = CLS_TRUE;
            else if (p[23:0] == le3("off") || p[23:0] == le3("Off")
                     || p[23:0] == le3("OFF"))
               k = CLS_FALSE;
         end
         3'd4: begin
            if (p[31:0] == le4("null") || p[31:0] == le4("Null")
                || p[31:0] == le4("NULL"))
               k = CLS_NULL;
            else if (p[31:0] == le4("true") || p[31:0] == le4("True")
                     || p[31:0] == le4("TRUE"))
               k = CLS_TRUE;
         end
         3'd5: begin
            if (p == le5("false") || p == le5("False") || p == le5("FALSE"))
               k = CLS_FALSE;
         end
         default: k = CLS_STRING;
      endcase
      return k;
   endfunction

endpackage

[rtl/core/pscls_req_if.sv]
// ----------------------------------------------------------------------------
// pscls_req_if
// Request channel: one scalar character with its end and quote marks.
// ----------------------------------------------------------------------------
interface pscls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;
   logic       empty_req;
   logic       quoted;

   modport source (output valid, character, last, empty_req, quoted, input ready);
   modport sink   (input valid, character, last, empty_req, quoted, output ready);
endinterface

[rtl/core/pscls_rsp_if.sv]
// ----------------------------------------------------------------------------
// pscls_rsp_if
// Response channel: scalar class and parsed integer value.
// ----------------------------------------------------------------------------
interface pscls_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         scalar_class;
   logic signed [63:0] integer_value;

   modport source (output valid, scalar_class, integer_value, input ready);
   modport sink   (input valid, scalar_class, integer_value, output ready);
endinterface

[rtl/core/pscls_scan.sv]
// ----------------------------------------------------------------------------
// pscls_scan
// Per-character scan state and the register holding a finished scalar.
// ----------------------------------------------------------------------------
module pscls_scan
   import pscls_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [CHAR_W-1:0]   character,
   input  logic                last,
   input  logic                empty_req,
   input  logic                quoted,
   output logic                fin_valid,
   output snap_type            fin_snap,
   input  logic                fin_take
);

   scan_type scan_ff, scan_in;
   scan_type step;
   logic     fin_valid_ff, fin_valid_in;
   snap_type fin_snap_ff, fin_snap_in;
   logic     accept, final_req;
   logic     is_sign, do_digit;
   logic     is_dec, is_lhex, is_uhex;

   assign req_ready = !fin_valid_ff || fin_take;
   assign accept    = req_valid && req_ready;
   assign final_req = accept && (last || empty_req);

   assign is_dec  = (character >= "0") && (character <= "9");
   assign is_lhex = (character >= "a") && (character <= "f");
   assign is_uhex = (character >= "A") && (character <= "F");
   assign is_sign = (character == "-") || (character == "+");

   always_comb begin
      step     = scan_ff;
      do_digit = 1'b0;
      if (scan_ff.count < 3'd5) begin
         step.prefix[{scan_ff.count, 3'b000} +: CHAR_W] = character;
      end
      if (scan_ff.count < 3'd6) begin
         step.count = scan_ff.count + 3'd1;
      end
      if (!scan_ff.not_int) begin
         if (is_sign) begin
            if (scan_ff.sign != SGN_NONE || scan_ff.phase != PH_PRE) begin
               step.not_int = 1'b1;
            end else begin
               step.sign = (character == "-") ? SGN_MINUS : SGN_PLUS;
            end
         end else begin
            unique case (scan_ff.phase)
               PH_PRE: begin
                  if (character == "0") begin
                     step.radix = RX_OCT;
                     step.phase = PH_SPEC;
                  end else begin
                     step.phase = PH_POST;
                     do_digit   = 1'b1;
                  end
               end
               PH_SPEC: begin
                  if (character == "b") begin
                     step.radix = RX_BIN;
                     step.phase = PH_POST;
                  end else if (character == "x") begin
                     step.radix = RX_HEX;
                     step.phase = PH_POST;
                  end else if ((character >= "0" && character <= "7")
                               || character == "_") begin
                     step.phase = PH_POST;
                     do_digit   = 1'b1;
                  end else begin
                     step.not_int = 1'b1;
                  end
               end
               default: do_digit = 1'b1;
            endcase
         end
         if (do_digit && character != "_") begin
            unique case (step.radix)
               RX_DEC: begin
                  if (is_dec) begin
                     step.acc = {scan_ff.acc[VALUE_W-4:0], 3'b000}
                              + {scan_ff.acc[VALUE_W-2:0], 1'b0}
                              + {{(VALUE_W-4){1'b0}}, character[3:0]};
                  end else begin
                     step.not_int = 1'b1;
                  end
               end
               RX_BIN: begin
                  if (character == "0" || character == "1") begin
                     step.acc = {scan_ff.acc[VALUE_W-2:0], character[0]};
                  end else begin
                     step.not_int = 1'b1;
                  end
               end
               RX_OCT: begin
                  if (character >= "0" && character <= "7") begin
                     step.acc = {scan_ff.acc[VALUE_W-4:0], character[2:0]};
                  end else begin
                     step.not_int = 1'b1;
                  end
               end
               default: begin
                  if (is_dec) begin
                     step.acc = {scan_ff.acc[VALUE_W-5:0], character[3:0]};
                  end else if (is_lhex || is_uhex) begin
                     step.acc = {scan_ff.acc[VALUE_W-5:0], character[3:0] + 4'd9};
                  end else begin
                     step.not_int = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_comb begin
      scan_in      = scan_ff;
      fin_valid_in = fin_valid_ff;
      fin_snap_in  = fin_snap_ff;
      if (fin_take) begin
         fin_valid_in = 1'b0;
      end
      if (accept) begin
         scan_in = final_req ? SCAN_CLEAR : step;
      end
      if (final_req) begin
         fin_valid_in       = 1'b1;
         fin_snap_in.scan   = empty_req ? scan_ff : step;
         fin_snap_in.quoted = quoted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= SCAN_CLEAR;
         fin_valid_ff <= 1'b0;
      end else begin
         scan_ff      <= scan_in;
         fin_valid_ff <= fin_valid_in;
      end
      fin_snap_ff <= fin_snap_in;
   end

   assign fin_valid = fin_valid_ff;
   assign fin_snap  = fin_snap_ff;

endmodule

[rtl/core/pscls_resolve.sv]
// ----------------------------------------------------------------------------
// pscls_resolve
// Keyword match, sign application and the response register.
// ----------------------------------------------------------------------------
module pscls_resolve
   import pscls_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                fin_valid,
   input  snap_type            fin_snap,
   output logic                fin_take,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CLASS_W-1:0]  scalar_class,
   output logic [VALUE_W-1:0]  integer_value
);

   logic               rsp_valid_ff, rsp_valid_in;
   class_type          class_ff, class_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   class_type          kw;

   assign fin_take = fin_valid && (!rsp_valid_ff || rsp_ready);
   assign kw       = kw_class(fin_snap.scan.prefix, fin_snap.scan.count);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      class_in     = class_ff;
      value_in     = value_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fin_take) begin
         rsp_valid_in = 1'b1;
         class_in     = CLS_STRING;
         value_in     = '0;
         if (!fin_snap.quoted) begin
            class_in = kw;
            if (kw == CLS_STRING && !fin_snap.scan.not_int) begin
               class_in = CLS_INTEGER;
               value_in = (fin_snap.scan.sign == SGN_MINUS) ? (~fin_snap.scan.acc + 64'd1)
                                                            : fin_snap.scan.acc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      class_ff <= class_in;
      value_ff <= value_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign scalar_class  = class_ff;
   assign integer_value = value_ff;

endmodule

[rtl/core/plain_scalar_classifier.sv]
// ----------------------------------------------------------------------------
// plain_scalar_classifier
// One request per cycle while req_ready is high; each scalar's result passes
// through the finished-scalar register, then the response register.
// Synchronous reset clears the scan state and empties both result stages.
// ----------------------------------------------------------------------------
module plain_scalar_classifier
   import pscls_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   pscls_req_if.sink    req_in,
   pscls_rsp_if.source  rsp_out
);

   logic     fin_valid, fin_take;
   snap_type fin_snap;
   logic [VALUE_W-1:0] value;

   pscls_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_in.valid),
      .req_ready (req_in.ready),
      .character (req_in.character),
      .last      (req_in.last),
      .empty_req (req_in.empty_req),
      .quoted    (req_in.quoted),
      .fin_valid (fin_valid),
      .fin_snap  (fin_snap),
      .fin_take  (fin_take)
   );

   pscls_resolve u_resolve (
      .clock         (clock),
      .reset         (reset),
      .fin_valid     (fin_valid),
      .fin_snap      (fin_snap),
      .fin_take      (fin_take),
      .rsp_valid     (rsp_out.valid),
      .rsp_ready     (rsp_out.ready),
      .scalar_class  (rsp_out.scalar_class),
      .integer_value (value)
   );

   assign rsp_out.integer_value = signed'(value);

endmodule

[tb/plain_scalar_classifier_test.sv]
// ----------------------------------------------------------------------------
// plain_scalar_classifier_test
// Streams scalar text into the classifier one character per request and checks
// every response against a cycle-free model of the scan: keyword lookup, signed
// integers in all four radixes with wraparound, quoted and empty scalars, and
// malformed or random text. Both channels idle at random, in short and long
// gaps, with stretches of full rate in between.
// ----------------------------------------------------------------------------
module plain_scalar_classifier_test
   import pscls_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       empty;
      logic       quoted;
   } req_item_type;

   typedef struct {
      class_type   cls;
      logic [63:0] val;
   } outcome_type;

   logic clock;
   logic reset;

   pscls_req_if req_if ();
   pscls_rsp_if rsp_if ();

   plain_scalar_classifier uut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_if),
      .rsp_out (rsp_if)
   );

   req_item_type char_queue[$];
   outcome_type  expected_q[$];
   logic [7:0]   text_q[$];
   req_item_type nxt;

   // model of the scan state
   logic [39:0] pfx;
   logic [2:0]  cnt;
   sign_type    sgn;
   phase_type   ph;
   radix_type   rdx;
   logic [63:0] mag;
   logic        bad;

   logic req_taken;
   int   req_gap, req_calm, rsp_stall, rsp_calm;
   int   fail_count, n_queued, n_scalars, n_checked, n_int, n_kw, n_str;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic int pause_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void clear_scan();
      pfx = '0;
      cnt = '0;
      sgn = SGN_NONE;
      ph  = PH_PRE;
      rdx = RX_DEC;
      mag = '0;
      bad = 1'b0;
   endfunction

   function automatic bit word_is(input string w);
      if (cnt != w.len()) return 1'b0;
      for (int i = 0; i < w.len(); i++)
         if (pfx[8*i +: 8] != w[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic class_type keyword_class();
      if (cnt > 3'd5) return CLS_STRING;
      if (cnt == 3'd0 || word_is("~") || word_is("null") || word_is("Null")
          || word_is("NULL"))
         return CLS_NULL;
      if (word_is("y") || word_is("Y") || word_is("yes") || word_is("Yes")
          || word_is("YES") || word_is("true") || word_is("True") || word_is("TRUE")
          || word_is("on") || word_is("On") || word_is("ON"))
         return CLS_TRUE;
      if (word_is("n") || word_is("N") || word_is("no") || word_is("No")
          || word_is("NO") || word_is("false") || word_is("False") || word_is("FALSE")
          || word_is("off") || word_is("Off") || word_is("OFF"))
         return CLS_FALSE;
      return CLS_STRING;
   endfunction

   function automatic void scan_digit(input logic [7:0] c);
      if (c == "-" || c == "+") begin
         if (sgn != SGN_NONE || ph != PH_PRE) bad = 1'b1;
         else sgn = (c == "-") ? SGN_MINUS : SGN_PLUS;
         return;
      end
      if (ph == PH_PRE) begin
         if (c == "0") begin
            rdx = RX_OCT;
            ph  = PH_SPEC;
            return;
         end
         ph = PH_POST;
      end else if (ph == PH_SPEC) begin
         if (c == "b") begin
            rdx = RX_BIN;
            ph  = PH_POST;
            return;
         end
         if (c == "x") begin
            rdx = RX_HEX;
            ph  = PH_POST;
            return;
         end
         if ((c >= "0" && c <= "7") || c == "_") begin
            ph = PH_POST;
         end else begin
            bad = 1'b1;
            return;
         end
      end
      if (c == "_") return;
      case (rdx)
         RX_DEC: begin
            if (c >= "0" && c <= "9") begin
               mag = mag * 64'd10 + 64'(c - "0");
               return;
            end
         end
         RX_BIN: begin
            if (c == "0" || c == "1") begin
               mag = {mag[62:0], c[0]};
               return;
            end
         end
         RX_OCT: begin
            if (c >= "0" && c <= "7") begin
               mag = {mag[60:0], c[2:0]};
               return;
            end
         end
         default: begin
            if (c >= "0" && c <= "9") begin
               mag = {mag[59:0], c[3:0]};
               return;
            end
            if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
               mag = {mag[59:0], 4'(c[3:0] + 4'd9)};
               return;
            end
         end
      endcase
      bad = 1'b1;
   endfunction

   task automatic take_char(input logic [7:0] c, input logic lst, input logic emp,
                            input logic q);
      outcome_type o;
      if (!emp) begin
         if (cnt < 3'd5) pfx[8*cnt +: 8] = c;
         if (cnt < 3'd6) cnt = cnt + 3'd1;
         if (!bad) scan_digit(c);
         if (!lst) return;
      end
      o.cls = CLS_STRING;
      o.val = '0;
      if (!q) begin
         o.cls = keyword_class();
         if (o.cls == CLS_STRING && !bad) begin
            o.cls = CLS_INTEGER;
            o.val = (sgn == SGN_MINUS) ? -mag : mag;
         end
      end
      expected_q.push_back(o);
      clear_scan();
   endtask

   task automatic put_str(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   task automatic put_digits(input string set, input int n);
      for (int i = 0; i < n; i++) begin
         text_q.push_back(set[$urandom_range(0, set.len() - 1)]);
         if ($urandom_range(0, 9) == 0) text_q.push_back("_");
      end
   endtask

   task automatic emit(input logic q, input logic via_empty);
      req_item_type it;
      int n;
      n = text_q.size();
      for (int i = 0; i < n; i++) begin
         it.ch     = text_q[i];
         it.last   = (i == n - 1) && !via_empty;
         it.empty  = 1'b0;
         it.quoted = it.last ? q : 1'($urandom_range(0, 1));
         char_queue.push_back(it);
      end
      if (via_empty || n == 0) begin
         it.ch     = 8'($urandom_range(0, 255));
         it.last   = 1'($urandom_range(0, 1));
         it.empty  = 1'b1;
         it.quoted = q;
         char_queue.push_back(it);
         n++;
      end
      n_queued += n;
      n_scalars++;
      text_q.delete();
   endtask

   task automatic put_sign();
      case ($urandom_range(0, 3))
         0: put_str("-");
         1: put_str("+");
         default: ;
      endcase
   endtask

   task automatic random_scalar();
      string kw_words[10];
      string w;
      int r;
      kw_words = '{"null", "true", "false", "yes", "no", "on", "off", "y", "n", "~"};
      r = $urandom_range(0, 99);
      if (r < 20) begin
         w = kw_words[$urandom_range(0, 9)];
         case ($urandom_range(0, 3))
            0: w = w.toupper();
            1: w.putc(0, w.substr(0, 0).toupper().getc(0));
            2: if (w.len() > 1) w.putc(w.len() - 1, w.substr(w.len() - 1,
                                                       w.len() - 1).toupper().getc(0));
            default: ;
         endcase
         put_str(w);
         if ($urandom_range(0, 7) == 0) put_str("s");
      end else if (r < 40) begin
         put_sign();
         put_digits("0123456789", $urandom_range(1, 22));
      end else if (r < 52) begin
         put_sign();
         put_str("0x");
         put_digits("0123456789abcdefABCDEF", $urandom_range(0, 20));
      end else if (r < 60) begin
         put_sign();
         put_str("0b");
         put_digits("01", $urandom_range(0, 70));
      end else if (r < 68) begin
         put_sign();
         put_str("0");
         put_digits("01234567", $urandom_range(0, 24));
      end else if (r < 78) begin
         case ($urandom_range(0, 5))
            0: begin
               put_str("0");
               text_q.push_back(8'($urandom_range(0, 255)));
               put_digits("0123", $urandom_range(0, 3));
            end
            1: begin
               put_str("0");
               if ($urandom_range(0, 1)) put_str("8");
               else if ($urandom_range(0, 1)) put_str("B1");
               else put_str("X1");
            end
            2: begin
               put_digits("0123456789", $urandom_range(1, 4));
               if ($urandom_range(0, 1)) put_str("-");
               else put_str("+");
               put_digits("0123456789", $urandom_range(0, 3));
            end
            3: begin
               put_str("0b");
               put_digits("0123", $urandom_range(1, 6));
            end
            4: begin
               put_str("0x");
               put_digits("0123456789abcdefg", $urandom_range(1, 6));
            end
            default: begin
               put_str("--");
               put_digits("0123456789", $urandom_range(0, 3));
            end
         endcase
      end else if (r < 88) begin
         repeat ($urandom_range(1, 7)) text_q.push_back(8'($urandom_range(0, 255)));
      end else if (r < 94) begin
         put_sign();
         put_digits("0123456789", $urandom_range(0, 3));
         put_str(".");
         put_digits("0123456789", $urandom_range(0, 3));
         if ($urandom_range(0, 1)) put_str("e3");
      end else begin
         case ($urandom_range(0, 4))
            0: put_str("-");
            1: put_str("+");
            2: put_str("_");
            3: begin
               if ($urandom_range(0, 1)) put_str("0b");
               else put_str("0x");
            end
            default: ;
         endcase
      end
      emit(1'($urandom_range(0, 9) == 0), 1'($urandom_range(0, 7) == 0));
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (char_queue.size() > 0) begin
            nxt = char_queue.pop_front();
            req_if.character <= nxt.ch;
            req_if.last      <= nxt.last;
            req_if.empty_req <= nxt.empty;
            req_if.quoted    <= nxt.quoted;
            req_if.valid     <= 1'b1;
            if (req_calm > 0) begin
               req_calm <= req_calm - 1;
            end else begin
               req_gap <= pause_len();
               if ($urandom_range(0, 99) == 0) req_calm <= $urandom_range(20, 100);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response backpressure
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_if.ready <= 1'b1;
         if (rsp_calm > 0) begin
            rsp_calm <= rsp_calm - 1;
         end else begin
            rsp_stall <= pause_len();
            if ($urandom_range(0, 99) == 0) rsp_calm <= $urandom_range(20, 100);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: response with nothing expected: class %0d value %0d",
                        $time, rsp_if.scalar_class, rsp_if.integer_value);
               fail_count++;
            end else begin
               automatic outcome_type e = expected_q.pop_front();
               n_checked++;
               if (rsp_if.scalar_class !== e.cls || rsp_if.integer_value !== e.val) begin
                  $display("%0t: response %0d expected class %0d value %0d, %s %0d %s %0d",
                           $time, n_checked, e.cls, $signed(e.val), "got class",
                           rsp_if.scalar_class, "value", rsp_if.integer_value);
                  fail_count++;
               end
               case (e.cls)
                  CLS_INTEGER: n_int++;
                  CLS_STRING:  n_str++;
                  default:     n_kw++;
               endcase
            end
         end
         if (req_if.valid && req_if.ready)
            take_char(req_if.character, req_if.last, req_if.empty_req, req_if.quoted);
      end
   end

   initial begin
      #20_000_000;
      $display("plain_scalar_classifier: mismatch");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_if.valid     = 1'b0;
      req_if.character = '0;
      req_if.last      = 1'b0;
      req_if.empty_req = 1'b0;
      req_if.quoted    = 1'b0;
      rsp_if.ready     = 1'b0;
      req_gap = 0;
      req_calm = 0;
      rsp_stall = 0;
      rsp_calm = 0;
      fail_count = 0;
      n_queued = 0;
      n_scalars = 0;
      n_checked = 0;
      n_int = 0;
      n_kw = 0;
      n_str = 0;
      clear_scan();

      // directed: empty, lone marks, radix edges, malformed, extremes
      emit(1'b0, 1'b1);
      emit(1'b1, 1'b1);
      put_str("~");   emit(1'b0, 1'b0);
      put_str("-");   emit(1'b0, 1'b0);
      put_str("_");   emit(1'b0, 1'b0);
      put_str("0x");  emit(1'b0, 1'b0);
      put_str("-7");  emit(1'b0, 1'b0);
      put_str("+-1"); emit(1'b0, 1'b0);
      put_str("08");  emit(1'b0, 1'b0);
      put_str("0X1"); emit(1'b0, 1'b0);
      put_str("1");   emit(1'b0, 1'b1);
      text_q.push_back(8'hff);
      text_q.push_back(8'h00);
      emit(1'b0, 1'b0);
      put_str("off"); emit(1'b1, 1'b0);

      while (n_queued < 1550) random_scalar();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (char_queue.size() > 0 || req_if.valid) @(posedge clock);
      while (expected_q.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("sent %0d requests forming %0d scalars", n_queued, n_scalars);
      $display("checked %0d responses: %0d integer, %0d keyword, %0d string",
               n_checked, n_int, n_kw, n_str);
      if (fail_count == 0) begin
         $display("plain_scalar_classifier: match");
      end else begin
         $display("plain_scalar_classifier: mismatch");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/pscls_pkg.sv
rtl/core/pscls_req_if.sv
rtl/core/pscls_rsp_if.sv
rtl/core/pscls_scan.sv
rtl/core/pscls_resolve.sv
rtl/core/plain_scalar_classifier.sv
tb/plain_scalar_classifier_test.sv
